>>> rtl/core/copf_pkg.sv
// ----------------------------------------------------------------------------
// copf_pkg
// Types and constants shared by the cascaded one-pole filter core and cells.
// ----------------------------------------------------------------------------
package copf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int STAGES_W   = 4;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFFICIENT   = 1'b0,
    REG_ACTIVE_STAGES = 1'b1
  } copf_reg_t;

  // Input transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       first_of_block;
  } copf_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } copf_out_t;

  // Control that travels with each sample down the chain
  typedef struct packed {
    logic valid;
    logic first;
    logic sat;
  } copf_ctl_t;

endpackage

>>> rtl/core/copf_cell.sv
// ----------------------------------------------------------------------------
// copf_cell
// One filter section: holds its own history, forms value + floor(h*c/2^15)
// with saturation, and registers the result for the next cell.
// ----------------------------------------------------------------------------
module copf_cell #(
  parameter int W     = 40,
  parameter bit IS_FF = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [copf_pkg::COEF_W-1:0]  coefficient,
  input  logic                                active,
  input  copf_pkg::copf_ctl_t                 in_ctl,
  input  logic signed [W-1:0]                 in_value,
  output copf_pkg::copf_ctl_t                 out_ctl,
  output logic signed [W-1:0]                 out_value
);

  localparam int SW = copf_pkg::SAMPLE_W;
  localparam int FW = copf_pkg::FRAC_W;
  localparam int CW = copf_pkg::COEF_W;

  logic signed [W-1:0]      hist_val;
  logic signed [W+CW-1:0]   prod;
  logic signed [W:0]        term;
  logic                     mul_sat;
  logic signed [W+1:0]      sum;
  logic signed [W-1:0]      sum_sat;
  logic                     add_sat;
  logic                     upd;

  // Commit history only for a live sample passing an active section
  assign upd = en && in_ctl.valid && active;

  generate
    if (IS_FF) begin : g_ff
      logic signed [SW-1:0] hist;
      // Feedforward section remembers the raw input sample
      assign hist_val = in_ctl.first ? '0 : {{(W-SW-FW){hist[SW-1]}}, hist, {FW{1'b0}}};
      always_ff @(posedge clk) begin
        if (rst) begin
          hist <= '0;
        end else if (upd) begin
          hist <= in_value[FW +: SW];
        end
      end
    end else begin : g_iir
      logic signed [W-1:0] hist;
      // Recursive section remembers its own saturated output
      assign hist_val = in_ctl.first ? '0 : hist;
      always_ff @(posedge clk) begin
        if (rst) begin
          hist <= '0;
        end else if (upd) begin
          hist <= sum_sat;
        end else if (en && in_ctl.valid && in_ctl.first) begin
          // An idle section still drops its history at the start of a block
          hist <= '0;
        end
      end
    end
  endgenerate

  // Multiply and drop the Q15 fraction (arithmetic shift floors)
  assign prod = hist_val * coefficient;

  always_comb begin
    term    = prod[W+CW-1:CW-1];
    mul_sat = 1'b0;
    // A full 64-bit word cannot hold +2^63: pin it one below
    if (W == 64 && term == {2'b01, {(W-1){1'b0}}}) begin
      term    = {2'b00, {(W-1){1'b1}}};
      mul_sat = 1'b1;
    end
  end

  // Add and saturate to the internal width
  assign sum = {{2{in_value[W-1]}}, in_value} + {term[W], term};

  always_comb begin
    add_sat = 1'b0;
    sum_sat = sum[W-1:0];
    if (!(sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111)) begin
      add_sat = 1'b1;
      sum_sat = sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  // Advance the chain register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.first <= in_ctl.first;
      out_ctl.sat   <= in_ctl.sat | (active & (mul_sat | add_sat));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= active ? sum_sat : in_value;
    end
  end

endmodule

>>> rtl/core/copf_out.sv
// ----------------------------------------------------------------------------
// copf_out
// Output stage: truncates toward zero, clamps to 16 bits, holds the result.
// ----------------------------------------------------------------------------
module copf_out #(
  parameter int W = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  copf_pkg::copf_ctl_t  in_ctl,
  input  logic signed [W-1:0]  in_value,
  output logic                 out_valid,
  output copf_pkg::copf_out_t  out_data
);

  localparam int SW = copf_pkg::SAMPLE_W;
  localparam int FW = copf_pkg::FRAC_W;

  logic signed [W-1:0]  adj;
  logic signed [W-1:0]  q;
  logic signed [SW-1:0] clamped;
  logic                 clamp;

  // Bias negative values so the shift rounds toward zero
  assign adj = in_value + (in_value[W-1] ? W'({FW{1'b1}}) : '0);
  assign q   = adj >>> FW;

  always_comb begin
    clamp   = 1'b0;
    clamped = q[SW-1:0];
    if (!(q[W-1:SW-1] == '0 || q[W-1:SW-1] == '1)) begin
      clamp   = 1'b1;
      clamped = q[W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.sample_out <= clamped;
      out_data.clipped    <= in_ctl.sat | clamp;
    end
  end

endmodule

>>> rtl/core/cascaded_one_pole_audio_filter_core.sv
// ----------------------------------------------------------------------------
// cascaded_one_pole_audio_filter_core
// Cascade of one feedforward and up to MAX_STAGES-1 one-pole sections with a
// shared Q1.15 coefficient, saturating fixed-point internals.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on in_valid/in_stall/in_data; a transaction completes at a
//   clock edge with in_valid high and in_stall low. Results leave on
//   out_valid/out_stall/out_data under the same rule.
//   The datapath is a row of MAX_STAGES cells, one per section, each holding
//   its own history and handing its sum to the next cell as the row advances,
//   then one output register. Every sample takes the whole row whatever the
//   active_stages setting; sections beyond it pass the value straight on.
//   Throughput is one sample per cycle while the receiver does not stall:
//   each cell's history feeds back combinationally into its own multiply-add.
//   When the receiver stalls with a result waiting, the whole row holds and
//   in_stall is raised until the result is taken.
//   Reset empties the row, clears all history, sets coefficient to 0 and
//   active_stages to 1. Write the registers on cfg_write/cfg_index/cfg_data
//   only while no sample is in flight.
// ----------------------------------------------------------------------------
module cascaded_one_pole_audio_filter_core #(
  parameter int MAX_STAGES     = 8,
  parameter int INTERNAL_WIDTH = 40
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [copf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [copf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  copf_pkg::copf_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output copf_pkg::copf_out_t                   out_data
);

  localparam int W  = INTERNAL_WIDTH;
  localparam int SW = copf_pkg::SAMPLE_W;
  localparam int FW = copf_pkg::FRAC_W;

  logic signed [copf_pkg::COEF_W-1:0] coefficient;
  logic [copf_pkg::STAGES_W-1:0]      active_stages;
  logic                               en;
  copf_pkg::copf_ctl_t                ctl [0:MAX_STAGES];
  logic signed [W-1:0]                val [0:MAX_STAGES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient   <= '0;
      active_stages <= copf_pkg::STAGES_W'(1);
    end else if (cfg_write) begin
      case (copf_pkg::copf_reg_t'(cfg_index))
        copf_pkg::REG_COEFFICIENT:   coefficient   <= cfg_data[copf_pkg::COEF_W-1:0];
        copf_pkg::REG_ACTIVE_STAGES: active_stages <= cfg_data[copf_pkg::STAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the row whenever the output register is free or being taken
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Head of the row: scale the sample to internal fixed point
  always_comb begin
    ctl[0].valid = in_valid;
    ctl[0].first = in_data.first_of_block;
    ctl[0].sat   = 1'b0;
    val[0]       = {{(W-SW-FW){in_data.sample_in[SW-1]}}, in_data.sample_in, {FW{1'b0}}};
  end

  // Row of sections; the first is feedforward and always active
  generate
    for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
      logic active;
      assign active = (k == 0) || (int'(active_stages) > k);

      copf_cell #(
        .W     (W),
        .IS_FF (k == 0)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .en          (en),
        .coefficient (coefficient),
        .active      (active),
        .in_ctl      (ctl[k]),
        .in_value    (val[k]),
        .out_ctl     (ctl[k+1]),
        .out_value   (val[k+1])
      );
    end
  endgenerate

  copf_out #(
    .W (W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (ctl[MAX_STAGES]),
    .in_value  (val[MAX_STAGES]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted sample occupies the first cell on the next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ctl[1].valid)
    else $error("accepted sample did not enter the first cell");

  // A stalled result freezes the tail of the row
  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(ctl[MAX_STAGES]) && $stable(val[MAX_STAGES]))
    else $error("tail of the row moved while the output was stalled");

  // A sample leaving the row reaches the output register
  a_tail_to_out: assert property (@(posedge clk) disable iff (rst)
    en && ctl[MAX_STAGES].valid |=> out_valid)
    else $error("sample lost between the last cell and the output");

  // Reset empties the output and the first cell
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !ctl[1].valid)
    else $error("row not empty after reset");

endmodule

>>> sim/tb_cascaded_one_pole_audio_filter_core.sv
// ----------------------------------------------------------------------------
// tb_cascaded_one_pole_audio_filter_core
// Self-checking bench for the cascaded one-pole audio filter core. A short
// directed table covers reset behaviour, full-scale samples, the coefficient
// extremes and out-of-range stage counts. Randomised phases with random
// register settings follow. Every accepted sample runs through a fixed-point
// filter model in the bench, and each output transaction is compared with
// the oldest predicted sample. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_cascaded_one_pole_audio_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_STAGES        = 8;
  localparam int ACC_W           = 40;
  localparam int LATENCY         = N_STAGES + 1;
  localparam int DRAIN_CYCLES    = 2 * LATENCY + 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RAND_ITEMS      = 1500;
  localparam int QUIET_ITEMS     = 150;
  localparam int MAX_REPORTS     = 10;
  localparam longint ACC_MAX     = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN     = -ACC_MAX - 1;

  typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_t;

  typedef enum int {STYLE_NOISE, STYLE_EDGE, STYLE_QUIET, STYLE_WALK, STYLE_DC} sample_style_t;

  typedef struct packed {
    row_kind_t                kind;
    copf_pkg::copf_reg_t      reg_idx;
    logic [15:0]              wdata;
    copf_pkg::copf_in_t       item;
    bit                       pinned;
    copf_pkg::copf_out_t      want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [copf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [copf_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  copf_pkg::copf_in_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  copf_pkg::copf_out_t             out_data;

  // Filter model state and register copy
  logic signed [15:0]              coef_q;
  logic [copf_pkg::STAGES_W-1:0]   stages_q;
  logic signed [15:0]              last_sample;
  longint                          stage_hist [1:N_STAGES-1];

  copf_pkg::copf_out_t             pending_filtered [$];
  stim_row_t                       dir_tab [$];

  bit                              pin_en;
  copf_pkg::copf_out_t             pin_want;
  bit                              quiet;
  bit                              gaps_on;
  int                              mismatches;
  int                              idle_run;
  int                              n_sent;
  int                              walk_level;
  logic signed [15:0]              dc_level;

  cascaded_one_pole_audio_filter_core #(
    .MAX_STAGES     (N_STAGES),
    .INTERNAL_WIDTH (ACC_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Fixed-point filter model
  // --------------------------------------------------------------------------

  // floor(v * c / 32768), exact for 40-bit values
  function automatic longint coef_term(longint v);
    return (v * longint'(coef_q)) >>> 15;
  endfunction

  function automatic longint clamp_acc(longint s, inout bit sat);
    if (s > ACC_MAX) begin
      sat = 1'b1;
      return ACC_MAX;
    end
    if (s < ACC_MIN) begin
      sat = 1'b1;
      return ACC_MIN;
    end
    return s;
  endfunction

  // Run one sample through the cascade and advance the history
  function automatic copf_pkg::copf_out_t filter_sample(copf_pkg::copf_in_t item);
    int unsigned         n;
    int                  k;
    longint              acc;
    longint              q;
    bit                  sat;
    logic signed [15:0]  x;
    copf_pkg::copf_out_t res;
    n = stages_q;
    if (n == 0) n = 1;
    if (n > N_STAGES) n = N_STAGES;
    sat = 1'b0;
    x = item.sample_in;
    if (item.first_of_block) begin
      last_sample = '0;
      for (k = 1; k < N_STAGES; k++) stage_hist[k] = 0;
    end
    // feedforward section
    acc = clamp_acc(longint'(x) * 256 + coef_term(longint'(last_sample) * 256), sat);
    last_sample = x;
    // recursive sections; the ones beyond the stage count keep their history but for a block start
    for (k = 1; k < n; k++) begin
      acc = clamp_acc(acc + coef_term(stage_hist[k]), sat);
      stage_hist[k] = acc;
    end
    // truncate toward zero, then clamp to 16 bits
    if (acc >= 0) q = acc >>> 8;
    else q = (acc + 255) >>> 8;
    if (q > 32767) begin
      q = 32767;
      sat = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      sat = 1'b1;
    end
    res.sample_out = q[15:0];
    res.clipped    = sat;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: track register writes, predict accepted samples, check output
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    copf_pkg::copf_out_t want;
    bit                  moved;
    if (rst) begin
      coef_q      = '0;
      stages_q    = 4'd1;
      last_sample = '0;
      foreach (stage_hist[k]) stage_hist[k] = 0;
      idle_run    = 0;
    end else begin
      moved = 1'b0;
      if (cfg_write) begin
        case (copf_pkg::copf_reg_t'(cfg_index))
          copf_pkg::REG_COEFFICIENT: begin
            coef_q = cfg_data;
          end
          copf_pkg::REG_ACTIVE_STAGES: begin
            stages_q = cfg_data[copf_pkg::STAGES_W-1:0];
          end
          default: ;
        endcase
      end
      // check the output transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_filtered.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected output: sample %0d clipped %0b", $realtime,
                     $signed(out_data.sample_out), out_data.clipped);
          mismatches++;
        end else begin
          want = pending_filtered.pop_front();
          if (out_data.sample_out !== want.sample_out || out_data.clipped !== want.clipped) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: mismatch: sample exp %0d got %0d, clipped exp %0b got %0b",
                       $realtime, $signed(want.sample_out), $signed(out_data.sample_out),
                       want.clipped, out_data.clipped);
            mismatches++;
          end
        end
      end
      // predict the accepted input transaction
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = filter_sample(in_data);
        if (pin_en) want = pin_want;
        pending_filtered.insert(pending_filtered.size(), want);
      end
      if (moved) idle_run = 0;
      else idle_run++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in random bursts, none in the quiet part of the run
  // --------------------------------------------------------------------------
  initial begin : rx_stall
    out_stall = 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_stall = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    wait (idle_run >= WATCHDOG_LIMIT);
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all entered and left just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send(copf_pkg::copf_in_t item, bit pinned, copf_pkg::copf_out_t want);
    if (gaps_on && !quiet && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    pin_en   = pinned;
    pin_want = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off until every predicted sample has come out
  task automatic drain();
    in_valid = 1'b0;
    while (pending_filtered.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(copf_pkg::copf_reg_t idx, logic [15:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_write(copf_pkg::copf_reg_t idx, logic [15:0] value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.wdata   = value;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic void add_item(logic signed [15:0] s, bit first, bit pinned,
                                   logic signed [15:0] want_s, bit want_c);
    stim_row_t row;
    row                     = '0;
    row.kind                = ROW_ITEM;
    row.item.sample_in      = s;
    row.item.first_of_block = first;
    row.pinned              = pinned;
    row.want.sample_out     = want_s;
    row.want.clipped        = want_c;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic logic signed [15:0] pick_sample(sample_style_t style);
    logic signed [15:0] edges [7] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                                      16'sh0001, 16'sh5555, -16'sh5556};
    case (style)
      STYLE_EDGE:  return edges[$urandom_range(0, 6)];
      STYLE_QUIET: return 16'(int'($urandom_range(0, 512)) - 256);
      STYLE_WALK: begin
        walk_level += int'($urandom_range(0, 4096)) - 2048;
        if (walk_level > 32767) walk_level = 32767;
        if (walk_level < -32768) walk_level = -32768;
        return 16'(walk_level);
      end
      STYLE_DC:    return dc_level;
      default:     return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'h7FFF;
      3: return 16'h0000;
      4: return 16'(32767 - int'($urandom_range(0, 300)));
      5: return 16'(-32767 + int'($urandom_range(0, 300)));
      default: return 16'($urandom);
    endcase
  endfunction

  // One register setting followed by a stream of sample blocks
  task automatic run_phase(int count);
    sample_style_t      style;
    copf_pkg::copf_in_t item;
    int                 block_left;
    drain();
    write_reg(copf_pkg::REG_COEFFICIENT, pick_coef());
    if ($urandom_range(0, 3) == 0)
      write_reg(copf_pkg::REG_ACTIVE_STAGES, 16'($urandom_range(0, 15)));
    else
      write_reg(copf_pkg::REG_ACTIVE_STAGES, 16'($urandom_range(1, N_STAGES)));
    style      = sample_style_t'($urandom_range(0, 4));
    gaps_on    = ($urandom_range(0, 9) < 7);
    dc_level   = ($urandom_range(0, 1) == 0) ? pick_sample(STYLE_EDGE) : 16'($urandom);
    block_left = 0;
    repeat (count) begin
      if (block_left == 0) begin
        item.first_of_block = 1'b1;
        block_left = $urandom_range(4, 80);
      end else begin
        item.first_of_block = ($urandom_range(0, 49) == 0);
      end
      block_left--;
      if ($urandom_range(0, 7) == 0)
        item.sample_in = pick_sample(sample_style_t'($urandom_range(0, 4)));
      else
        item.sample_in = pick_sample(style);
      send(item, 1'b0, '0);
      n_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    pin_en     = 1'b0;
    pin_want   = '0;
    quiet      = 1'b0;
    gaps_on    = 1'b1;
    mismatches = 0;
    idle_run   = 0;
    n_sent     = 0;
    walk_level = 0;
    dc_level   = '0;

    // after reset the coefficient is zero: samples pass straight through
    add_item(16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b0);
    add_item(-16'sh8000, 1'b0, 1'b1, -16'sh8000, 1'b0);
    add_item(16'sh0000, 1'b0, 1'b1, 16'sh0000, 1'b0);
    add_item(16'sh0001, 1'b0, 1'b1, 16'sh0001, 1'b0);
    // largest positive coefficient: a repeated full-scale sample clamps
    add_write(copf_pkg::REG_COEFFICIENT, 16'h7FFF);
    add_item(16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b0);
    add_item(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF, 1'b1);
    add_item(-16'sh8000, 1'b0, 1'b0, '0, 1'b0);
    // coefficient of exactly -1.0 with every stage in use
    add_write(copf_pkg::REG_COEFFICIENT, 16'h8000);
    add_write(copf_pkg::REG_ACTIVE_STAGES, 16'd8);
    add_item(-16'sh8000, 1'b1, 1'b1, -16'sh8000, 1'b0);
    add_item(-16'sh8000, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sh7FFF, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sh0000, 1'b0, 1'b0, '0, 1'b0);
    // zero stages behaves as one; half coefficient
    add_write(copf_pkg::REG_COEFFICIENT, 16'h4000);
    add_write(copf_pkg::REG_ACTIVE_STAGES, 16'd0);
    add_item(16'sd1000, 1'b1, 1'b1, 16'sd1000, 1'b0);
    add_item(16'sd1000, 1'b0, 1'b1, 16'sd1500, 1'b0);
    add_item(-16'sh0001, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sh0000, 1'b0, 1'b1, 16'sh0000, 1'b0);
    // stage count above the maximum acts as the maximum
    add_write(copf_pkg::REG_COEFFICIENT, 16'h8001);
    add_write(copf_pkg::REG_ACTIVE_STAGES, 16'd15);
    add_item(16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b0);
    add_item(-16'sh8000, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sh7FFF, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sd12345, 1'b0, 1'b0, '0, 1'b0);
    // fewer stages, then back to all: idle stages must keep their history
    add_write(copf_pkg::REG_COEFFICIENT, 16'd30000);
    add_write(copf_pkg::REG_ACTIVE_STAGES, 16'd3);
    add_item(16'sd20000, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sd20000, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sd20000, 1'b0, 1'b0, '0, 1'b0);
    add_item(-16'sd20000, 1'b0, 1'b0, '0, 1'b0);
    add_write(copf_pkg::REG_ACTIVE_STAGES, 16'd8);
    add_item(16'sd5, 1'b0, 1'b0, '0, 1'b0);
    add_item(16'sd5, 1'b0, 1'b0, '0, 1'b0);

    // hold reset, release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].wdata);
      end else begin
        send(dir_tab[i].item, dir_tab[i].pinned, dir_tab[i].want);
      end
    end

    // random phases, then a last phase without any idling
    n_sent = 0;
    while (n_sent < RAND_ITEMS - QUIET_ITEMS) run_phase($urandom_range(60, 140));
    quiet = 1'b1;
    run_phase(QUIET_ITEMS);

    // let the pipeline empty, then watch for stray output
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_filtered.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> cascaded_one_pole_audio_filter_core.f
rtl/core/copf_pkg.sv
rtl/core/copf_cell.sv
rtl/core/copf_out.sv
rtl/core/cascaded_one_pole_audio_filter_core.sv
sim/tb_cascaded_one_pole_audio_filter_core.sv
